/* sv/mse_pkg.sv */
package mse_pkg;

    // Data path and register file geometry
    localparam int XLEN      = 32;
    localparam int NREGS     = 32;
    localparam int RIDX_W    = 5;

    localparam logic [XLEN-1:0] START_ADDR_RESET = 32'h0000_1000;
    localparam logic [XLEN-1:0] PC_REGION_MASK   = 32'hf000_0000;
    localparam logic [RIDX_W-1:0] LINK_REG       = 5'd31;
    localparam logic [RIDX_W-1:0] REG_V0         = 5'd2;
    localparam logic [RIDX_W-1:0] REG_A0         = 5'd4;

    // Item kinds on the input channel
    localparam logic ACT_EXEC   = 1'b0;
    localparam logic ACT_LDRET  = 1'b1;

    // Result event codes
    localparam logic [2:0] EV_FETCH   = 3'd0;
    localparam logic [2:0] EV_LOAD    = 3'd1;
    localparam logic [2:0] EV_STORE   = 3'd2;
    localparam logic [2:0] EV_SYSCALL = 3'd3;
    localparam logic [2:0] EV_ILLEGAL = 3'd4;

    // Pending load kinds
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_LB   = 2'd1;
    localparam logic [1:0] PEND_LBU  = 2'd2;
    localparam logic [1:0] PEND_LW   = 2'd3;

    // Primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0a;
    localparam logic [5:0] OP_SLTIU   = 6'h0b;
    localparam logic [5:0] OP_ANDI    = 6'h0c;
    localparam logic [5:0] OP_ORI     = 6'h0d;
    localparam logic [5:0] OP_XORI    = 6'h0e;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SW      = 6'h2b;

    // SPECIAL function codes
    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_JALR    = 6'h09;
    localparam logic [5:0] FN_SYSCALL = 6'h0c;
    localparam logic [5:0] FN_MFHI    = 6'h10;
    localparam logic [5:0] FN_MFLO    = 6'h12;
    localparam logic [5:0] FN_MULT    = 6'h18;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_NOR     = 6'h27;
    localparam logic [5:0] FN_SLT     = 6'h2a;
    localparam logic [5:0] FN_SLTU    = 6'h2b;

    // Architectural state seen by the execute logic
    typedef struct packed {
        logic [XLEN-1:0]   pc;
        logic [XLEN-1:0]   hi;
        logic [XLEN-1:0]   lo;
        logic [1:0]        pend_kind;
        logic [RIDX_W-1:0] pend_dest;
        logic              halted;
    } mse_state_t;

    // Everything one item produces: the result item and the state updates
    typedef struct packed {
        logic              has_result;
        logic [2:0]        kind;
        logic [XLEN-1:0]   npc;
        logic [XLEN-1:0]   addr;
        logic              is_word;
        logic [XLEN-1:0]   sdata;
        logic [XLEN-1:0]   cnum;
        logic [XLEN-1:0]   carg;
        logic              rf_we;
        logic [RIDX_W-1:0] rf_waddr;
        logic [XLEN-1:0]   rf_wdata;
        logic              pc_we;
        logic [XLEN-1:0]   pc_val;
        logic              hilo_we;
        logic [XLEN-1:0]   hi_val;
        logic [XLEN-1:0]   lo_val;
        logic              pend_we;
        logic [1:0]        pend_kind;
        logic [RIDX_W-1:0] pend_dest;
        logic              halt;
    } mse_exec_t;

endpackage

/* sv/mse_ram.sv */
module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    // One write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Two registered read ports, old data on a same-cycle write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

/* sv/mse_exec.sv */
module mse_exec (
    input  logic                       action,
    input  logic [mse_pkg::XLEN-1:0]   instruction,
    input  logic [mse_pkg::XLEN-1:0]   load_data,
    input  logic [mse_pkg::XLEN-1:0]   vs,
    input  logic [mse_pkg::XLEN-1:0]   vt,
    input  logic [mse_pkg::XLEN-1:0]   reg_v0,
    input  logic [mse_pkg::XLEN-1:0]   reg_a0,
    input  mse_pkg::mse_state_t        st,
    output mse_pkg::mse_exec_t         res
);

    logic [5:0]                  op;
    logic [5:0]                  fn;
    logic [mse_pkg::RIDX_W-1:0]  rt;
    logic [mse_pkg::RIDX_W-1:0]  rd;
    logic [4:0]                  sh;
    logic [mse_pkg::XLEN-1:0]    imm_z;
    logic [mse_pkg::XLEN-1:0]    imm_s;
    logic [mse_pkg::XLEN-1:0]    pc4;
    logic [mse_pkg::XLEN-1:0]    jtarget;
    logic [mse_pkg::XLEN-1:0]    btarget;
    logic [mse_pkg::XLEN-1:0]    addr;
    logic signed [2*mse_pkg::XLEN-1:0] prod;
    logic                        wr;
    logic [mse_pkg::RIDX_W-1:0]  wa;
    logic [mse_pkg::XLEN-1:0]    wd;
    logic [mse_pkg::XLEN-1:0]    ld_val;

    // Field split and common address math
    assign op        = instruction[31:26];
    assign rt        = instruction[20:16];
    assign rd        = instruction[15:11];
    assign sh        = instruction[10:6];
    assign fn        = instruction[5:0];
    assign imm_z     = {16'h0000, instruction[15:0]};
    assign imm_s     = {{16{instruction[15]}}, instruction[15:0]};
    assign pc4       = st.pc + 32'd4;
    assign jtarget   = (pc4 & mse_pkg::PC_REGION_MASK) | {4'h0, instruction[25:0], 2'b00};
    assign btarget   = pc4 + {imm_s[29:0], 2'b00};
    assign addr      = vs + imm_s;
    assign prod      = $signed(vs) * $signed(vt);

    // Load return data shaping
    always_comb
    begin
        case (st.pend_kind)
            mse_pkg::PEND_LB:  ld_val = {{24{load_data[7]}}, load_data[7:0]};
            mse_pkg::PEND_LBU: ld_val = {24'h000000, load_data[7:0]};
            default:           ld_val = load_data;
        endcase
    end

    // Decode and execute
    always_comb
    begin
        res            = '0;
        res.has_result = 1'b1;
        res.kind       = mse_pkg::EV_FETCH;
        res.npc        = pc4;
        res.pc_val     = pc4;
        res.hi_val     = prod[63:32];
        res.lo_val     = prod[31:0];
        res.pend_kind  = mse_pkg::PEND_NONE;
        res.pend_dest  = '0;
        wr             = 1'b0;
        wa             = rd;
        wd             = '0;

        if (st.halted)
        begin
            res.kind = mse_pkg::EV_ILLEGAL;
            res.npc  = st.pc;
        end
        else if (action == mse_pkg::ACT_LDRET)
        begin
            if (st.pend_kind == mse_pkg::PEND_NONE)
            begin
                res.has_result = 1'b0;
            end
            else
            begin
                wr          = 1'b1;
                wa          = st.pend_dest;
                wd          = ld_val;
                res.pend_we = 1'b1;
                res.npc     = st.pc;
            end
        end
        else if (st.pend_kind != mse_pkg::PEND_NONE)
        begin
            res.has_result = 1'b0;
        end
        else
        begin
            res.pc_we = 1'b1;
            case (op)
                mse_pkg::OP_SPECIAL:
                begin
                    case (fn)
                        mse_pkg::FN_SYSCALL:
                        begin
                            res.kind = mse_pkg::EV_SYSCALL;
                            res.cnum = reg_v0;
                            res.carg = reg_a0;
                        end
                        mse_pkg::FN_SLL:  begin wr = 1'b1; wd = vt << sh; end
                        mse_pkg::FN_SRL:  begin wr = 1'b1; wd = vt >> sh; end
                        mse_pkg::FN_SRA:  begin wr = 1'b1; wd = $unsigned($signed(vt) >>> sh); end
                        mse_pkg::FN_JR:   res.npc = vs;
                        mse_pkg::FN_JALR: begin res.npc = vs; wr = 1'b1; wd = pc4; end
                        mse_pkg::FN_MFHI: begin wr = 1'b1; wd = st.hi; end
                        mse_pkg::FN_MFLO: begin wr = 1'b1; wd = st.lo; end
                        mse_pkg::FN_MULT: res.hilo_we = 1'b1;
                        mse_pkg::FN_ADDU: begin wr = 1'b1; wd = vs + vt; end
                        mse_pkg::FN_SUBU: begin wr = 1'b1; wd = vs - vt; end
                        mse_pkg::FN_AND:  begin wr = 1'b1; wd = vs & vt; end
                        mse_pkg::FN_OR:   begin wr = 1'b1; wd = vs | vt; end
                        mse_pkg::FN_XOR:  begin wr = 1'b1; wd = vs ^ vt; end
                        mse_pkg::FN_NOR:  begin wr = 1'b1; wd = ~(vs | vt); end
                        mse_pkg::FN_SLT:
                        begin
                            wr = 1'b1;
                            wd = {31'd0, $signed(vs) < $signed(vt)};
                        end
                        mse_pkg::FN_SLTU:
                        begin
                            wr = 1'b1;
                            wd = {31'd0, vs < vt};
                        end
                        default:
                        begin
                            res.halt  = 1'b1;
                            res.pc_we = 1'b0;
                            res.kind  = mse_pkg::EV_ILLEGAL;
                            res.npc   = st.pc;
                        end
                    endcase
                end
                mse_pkg::OP_J:     res.npc = jtarget;
                mse_pkg::OP_JAL:
                begin
                    res.npc = jtarget;
                    wr      = 1'b1;
                    wa      = mse_pkg::LINK_REG;
                    wd      = pc4;
                end
                mse_pkg::OP_BEQ:   if (vs == vt) res.npc = btarget;
                mse_pkg::OP_BNE:   if (vs != vt) res.npc = btarget;
                mse_pkg::OP_ADDIU: begin wr = 1'b1; wa = rt; wd = addr; end
                mse_pkg::OP_SLTI:
                begin
                    wr = 1'b1;
                    wa = rt;
                    wd = {31'd0, $signed(vs) < $signed(imm_s)};
                end
                mse_pkg::OP_SLTIU:
                begin
                    wr = 1'b1;
                    wa = rt;
                    wd = {31'd0, vs < imm_s};
                end
                mse_pkg::OP_ANDI:  begin wr = 1'b1; wa = rt; wd = vs & imm_z; end
                mse_pkg::OP_ORI:   begin wr = 1'b1; wa = rt; wd = vs | imm_z; end
                mse_pkg::OP_XORI:  begin wr = 1'b1; wa = rt; wd = vs ^ imm_z; end
                mse_pkg::OP_LUI:
                begin
                    wr = 1'b1;
                    wa = rt;
                    wd = {instruction[15:0], 16'h0000};
                end
                mse_pkg::OP_LB, mse_pkg::OP_LW, mse_pkg::OP_LBU:
                begin
                    res.kind      = mse_pkg::EV_LOAD;
                    res.addr      = addr;
                    res.is_word   = (op == mse_pkg::OP_LW);
                    res.pend_we   = 1'b1;
                    res.pend_dest = rt;
                    if (op == mse_pkg::OP_LB)
                    begin
                        res.pend_kind = mse_pkg::PEND_LB;
                    end
                    else if (op == mse_pkg::OP_LBU)
                    begin
                        res.pend_kind = mse_pkg::PEND_LBU;
                    end
                    else
                    begin
                        res.pend_kind = mse_pkg::PEND_LW;
                    end
                end
                mse_pkg::OP_SB, mse_pkg::OP_SW:
                begin
                    res.kind    = mse_pkg::EV_STORE;
                    res.addr    = addr;
                    res.is_word = (op == mse_pkg::OP_SW);
                    res.sdata   = (op == mse_pkg::OP_SW) ? vt : {24'h000000, vt[7:0]};
                end
                default:
                begin
                    res.halt  = 1'b1;
                    res.pc_we = 1'b0;
                    res.kind  = mse_pkg::EV_ILLEGAL;
                    res.npc   = st.pc;
                end
            endcase
            res.pc_val = res.npc;
        end

        // Register 0 is never written
        res.rf_we    = wr && (wa != '0);
        res.rf_waddr = wa;
        res.rf_wdata = wd;
    end

endmodule

/* sv/mips_subset_execute_top.sv */
// Channel  | Dir | Handshake           | Payload
// ---------+-----+---------------------+-----------------------------------------------
// in       | in  | in_valid / in_stall | action, instruction, load_data
// out      | out | out_valid/out_stall | event_kind, next_pc, mem_address, mem_is_word,
//          |     |                     | store_data, call_number, call_argument
// cfg      | in  | cfg_valid/cfg_ready | start_address (also loads the pc)
//
// One item per cycle sustained while out_stall is low; results leave from the result register.
// Accept reads rs/rt from the register file RAM; execute then runs from the
// input register and writes the result register and all state at one edge.
// A write in the execute cycle that hits the following item's rs/rt is forwarded.
// Reset clears all state; pc comes up at 0x1000; no clearing pass is needed.
// A stalled result holds the execute stage, and that backs up into in_stall.
module mips_subset_execute_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [31:0] instruction,
    input  logic [31:0] load_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_kind,
    output logic [31:0] next_pc,
    output logic [31:0] mem_address,
    output logic        mem_is_word,
    output logic [31:0] store_data,
    output logic [31:0] call_number,
    output logic [31:0] call_argument,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] start_address
);

    localparam int XL = mse_pkg::XLEN;
    localparam int RW = mse_pkg::RIDX_W;

    logic                in_take;
    logic                exec_go;
    logic                cfg_take;

    // Input stage
    logic                in_valid_reg;
    logic                in_valid_next;
    logic                action_reg;
    logic [XL-1:0]       instr_reg;
    logic [XL-1:0]       ldata_reg;

    // Register file read support
    logic [mse_pkg::NREGS-1:0] rf_valid_reg;
    logic                vld_a_reg;
    logic                vld_b_reg;
    logic                byp_a_reg;
    logic                byp_b_reg;
    logic [XL-1:0]       byp_data_reg;
    logic [XL-1:0]       ram_qa;
    logic [XL-1:0]       ram_qb;
    logic [XL-1:0]       vs;
    logic [XL-1:0]       vt;
    logic [RW-1:0]       rs_in;
    logic [RW-1:0]       rt_in;
    logic [XL-1:0]       v0_reg;
    logic [XL-1:0]       a0_reg;

    // Architectural state
    logic [XL-1:0]       pc_reg;
    logic [XL-1:0]       hi_reg;
    logic [XL-1:0]       lo_reg;
    logic [1:0]          pend_kind_reg;
    logic [RW-1:0]       pend_dest_reg;
    logic                halted_reg;
    mse_pkg::mse_state_t st;
    mse_pkg::mse_exec_t  res;

    // Result register
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [2:0]          kind_reg;
    logic [XL-1:0]       npc_reg;
    logic [XL-1:0]       addr_reg;
    logic                word_reg;
    logic [XL-1:0]       sdata_reg;
    logic [XL-1:0]       cnum_reg;
    logic [XL-1:0]       carg_reg;

    logic                rf_we;

    // Handshakes
    assign exec_go   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !exec_go;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign cfg_take  = cfg_valid && cfg_ready;
    assign rf_we     = exec_go && res.rf_we;

    assign rs_in = instruction[25:21];
    assign rt_in = instruction[20:16];

    // Input register
    assign in_valid_next = in_take ? 1'b1 : (exec_go ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            action_reg   <= action;
            instr_reg    <= instruction;
            ldata_reg    <= load_data;
            vld_a_reg    <= rf_valid_reg[rs_in];
            vld_b_reg    <= rf_valid_reg[rt_in];
            byp_a_reg    <= rf_we && (res.rf_waddr == rs_in);
            byp_b_reg    <= rf_we && (res.rf_waddr == rt_in);
            byp_data_reg <= res.rf_wdata;
        end
    end

    // Register file storage, read at accept
    mse_ram #(
        .WIDTH (XL),
        .DEPTH (mse_pkg::NREGS)
    ) u_rf (
        .clk     (clk),
        .we      (rf_we),
        .waddr   (res.rf_waddr),
        .wdata   (res.rf_wdata),
        .re      (in_take),
        .raddr_a (rs_in),
        .raddr_b (rt_in),
        .rdata_a (ram_qa),
        .rdata_b (ram_qb)
    );

    // Operand select: forwarded write, stored value, or zero if never written
    assign vs = byp_a_reg ? byp_data_reg : (vld_a_reg ? ram_qa : '0);
    assign vt = byp_b_reg ? byp_data_reg : (vld_b_reg ? ram_qb : '0);

    // Written-entry flags and syscall argument copies
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg <= '0;
            v0_reg       <= '0;
            a0_reg       <= '0;
        end
        else if (rf_we)
        begin
            rf_valid_reg[res.rf_waddr] <= 1'b1;
            if (res.rf_waddr == mse_pkg::REG_V0)
            begin
                v0_reg <= res.rf_wdata;
            end
            if (res.rf_waddr == mse_pkg::REG_A0)
            begin
                a0_reg <= res.rf_wdata;
            end
        end
    end

    assign st.pc        = pc_reg;
    assign st.hi        = hi_reg;
    assign st.lo        = lo_reg;
    assign st.pend_kind = pend_kind_reg;
    assign st.pend_dest = pend_dest_reg;
    assign st.halted    = halted_reg;

    mse_exec u_exec (
        .action      (action_reg),
        .instruction (instr_reg),
        .load_data   (ldata_reg),
        .vs          (vs),
        .vt          (vt),
        .reg_v0      (v0_reg),
        .reg_a0      (a0_reg),
        .st          (st),
        .res         (res)
    );

    // Architectural state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= mse_pkg::START_ADDR_RESET;
            hi_reg        <= '0;
            lo_reg        <= '0;
            pend_kind_reg <= mse_pkg::PEND_NONE;
            pend_dest_reg <= '0;
            halted_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_take)
            begin
                pc_reg <= start_address;
            end
            else if (exec_go && res.pc_we)
            begin
                pc_reg <= res.pc_val;
            end
            if (exec_go && res.hilo_we)
            begin
                hi_reg <= res.hi_val;
                lo_reg <= res.lo_val;
            end
            if (exec_go && res.pend_we)
            begin
                pend_kind_reg <= res.pend_kind;
                pend_dest_reg <= res.pend_dest;
            end
            if (exec_go && res.halt)
            begin
                halted_reg <= 1'b1;
            end
        end
    end

    // Result register
    assign out_valid_next = (exec_go && res.has_result) ? 1'b1
                          : (out_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_go && res.has_result)
        begin
            kind_reg  <= res.kind;
            npc_reg   <= res.npc;
            addr_reg  <= res.addr;
            word_reg  <= res.is_word;
            sdata_reg <= res.sdata;
            cnum_reg  <= res.cnum;
            carg_reg  <= res.carg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_kind    = kind_reg;
    assign next_pc       = npc_reg;
    assign mem_address   = addr_reg;
    assign mem_is_word   = word_reg;
    assign store_data    = sdata_reg;
    assign call_number   = cnum_reg;
    assign call_argument = carg_reg;

    // Checks
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt flag cleared without reset");

    a_illegal_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_go && res.halt) |=> halted_reg)
        else $error("illegal item did not halt the core");

    a_no_write_halted: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> !res.rf_we && !res.hilo_we && !res.pend_we)
        else $error("state update while halted");

    a_r0_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !rf_valid_reg[0])
        else $error("register zero written");

    a_pending_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_kind_reg != mse_pkg::PEND_NONE && action_reg == mse_pkg::ACT_EXEC)
        |-> !res.has_result && !res.rf_we)
        else $error("instruction executed while a load is pending");

endmodule
